// ===== rtl/mdsp_pkg.sv =====
// Package for the multi-line dot-stuffing parser: phase codes, status codes,
// byte constants and the result entry type. No dependencies.
`default_nettype none

package mdsp_pkg;

  // Longest line in bytes before the parser flags an error
  localparam int unsigned MAX_LINE   = 512;
  localparam int unsigned LINE_CNT_W = 10;

  // Depth of the result queue (power of two, at least 4)
  localparam int unsigned OUT_DEPTH_DEF = 4;

  // Parser phase codes
  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_BODY  = 3'd1;
  localparam logic [2:0] PH_DOT   = 3'd2;
  localparam logic [2:0] PH_DOTCR = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [2:0] PH_ERROR = 3'd5;

  // Status codes carried on every result
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DOT = 8'h2E;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       to_first_line;
    logic       last;
    logic [1:0] status;
  } res_t;

endpackage : mdsp_pkg

`default_nettype wire

// ===== rtl/multiline_dot_stuffing_parser.sv =====
// Multi-line dot-stuffing parser, top level: parse logic plus result queue.
// Depends on mdsp_pkg.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+------------------------------------
//   in      | sink      | in_valid_i / in_stall_o    | in_byte_i
//   out     | source    | out_valid_o / out_stall_i  | out_byte_o, out_has_byte_o,
//           |           |                            | out_to_first_line_o, out_last_o,
//           |           |                            | out_status_o
//   cfg     | sink      | cfg_we_i                   | cfg_wdata_i (unstuff_mode)
//
// Cycles: one byte is taken per cycle while in_stall_o is low; its one or two
//   results are written into the result queue at the accepting edge and leave it one per cycle.
//   Sustained rate is one byte per cycle while bytes make one result each;
//   two-result bytes are limited by the single-entry-per-cycle output.
// Reset: phase goes to first line, counters clear, unstuff mode is set.
// Stalls: in_stall_o rises when the queue cannot take two more entries;
//   out_stall_i simply holds the queue head.
`default_nettype none

module multiline_dot_stuffing_parser #(
  parameter int unsigned OUT_DEPTH = mdsp_pkg::OUT_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  // input bytes
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  // results
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_has_byte_o,
  output logic            out_to_first_line_o,
  output logic            out_last_o,
  output logic [1:0]      out_status_o
);

  localparam int unsigned PtrW = $clog2(OUT_DEPTH);
  localparam int unsigned CntW = $clog2(OUT_DEPTH + 1);
  localparam logic [CntW-1:0] StallAt = CntW'(OUT_DEPTH - 2);
  localparam logic [mdsp_pkg::LINE_CNT_W-1:0] MaxLine =
    mdsp_pkg::LINE_CNT_W'(mdsp_pkg::MAX_LINE);

  // ------------------------------------------------------------------
  // Parser state
  // ------------------------------------------------------------------
  logic                              unstuff_q;
  logic [2:0]                        phase_q, phase_d;
  logic                              cr_q, cr_d;
  logic [mdsp_pkg::LINE_CNT_W-1:0]   lcnt_q, lcnt_d;

  logic       in_fire;
  logic       out_fire;
  logic [1:0] e_n;         // bytes emitted by this input byte
  logic [7:0] e0, e1;
  logic       e0_first;
  logic       line_end;
  logic [1:0] st;
  mdsp_pkg::res_t ent0, ent1;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  // One pass of the parse: next state and emitted bytes from the current
  // state and the incoming byte.
  always_comb begin
    phase_d  = phase_q;
    cr_d     = cr_q;
    lcnt_d   = lcnt_q;
    e_n      = 2'd0;
    e0       = '0;
    e1       = '0;
    e0_first = 1'b0;
    line_end = 1'b0;
    if (phase_q != mdsp_pkg::PH_DONE && phase_q != mdsp_pkg::PH_ERROR &&
        phase_q <= mdsp_pkg::PH_ERROR) begin
      unique case (phase_q)
        mdsp_pkg::PH_FIRST: begin
          // status line passes through untouched
          e_n      = 2'd1;
          e0       = in_byte_i;
          e0_first = unstuff_q;
          if (in_byte_i == mdsp_pkg::CH_LF) begin
            phase_d  = mdsp_pkg::PH_BODY;
            line_end = 1'b1;
          end
        end
        mdsp_pkg::PH_BODY: begin
          if (in_byte_i == mdsp_pkg::CH_DOT && lcnt_q == '0) begin
            if (!unstuff_q) begin
              e_n = 2'd1;
              e0  = in_byte_i;
            end
            phase_d = mdsp_pkg::PH_DOT;
            cr_d    = 1'b0;
          end else if (in_byte_i == mdsp_pkg::CH_CR) begin
            // CR is held back in unstuff mode until its LF turns up
            if (!unstuff_q) begin
              e_n = 2'd1;
              e0  = in_byte_i;
            end
            cr_d = 1'b1;
          end else if (in_byte_i == mdsp_pkg::CH_LF) begin
            if (cr_q) begin
              if (unstuff_q) begin
                e_n = 2'd2;
                e0  = mdsp_pkg::CH_CR;
                e1  = mdsp_pkg::CH_LF;
              end else begin
                e_n = 2'd1;
                e0  = mdsp_pkg::CH_LF;
              end
              cr_d     = 1'b0;
              line_end = 1'b1;
            end else if (!unstuff_q) begin
              // bare LF gains a CR
              e_n      = 2'd2;
              e0       = mdsp_pkg::CH_CR;
              e1       = mdsp_pkg::CH_LF;
              line_end = 1'b1;
            end else begin
              phase_d = mdsp_pkg::PH_ERROR;
            end
          end else begin
            e_n = 2'd1;
            e0  = in_byte_i;
          end
        end
        mdsp_pkg::PH_DOT: begin
          if (unstuff_q) begin
            if (in_byte_i == mdsp_pkg::CH_CR) begin
              phase_d = mdsp_pkg::PH_DOTCR;
              cr_d    = 1'b0;
            end else if (in_byte_i == mdsp_pkg::CH_DOT) begin
              e_n     = 2'd1;
              e0      = mdsp_pkg::CH_DOT;
              phase_d = mdsp_pkg::PH_BODY;
              cr_d    = 1'b0;
            end else begin
              phase_d = mdsp_pkg::PH_ERROR;
            end
          end else begin
            // stuffing: the extra dot, then the byte itself
            phase_d = mdsp_pkg::PH_BODY;
            cr_d    = (in_byte_i == mdsp_pkg::CH_CR);
            if (in_byte_i == mdsp_pkg::CH_LF) begin
              phase_d = mdsp_pkg::PH_ERROR;
            end
            e_n = 2'd2;
            e0  = mdsp_pkg::CH_DOT;
            e1  = in_byte_i;
          end
        end
        default: begin
          // after dot CR: only LF completes the terminator
          phase_d = (in_byte_i == mdsp_pkg::CH_LF) ? mdsp_pkg::PH_DONE
                                                   : mdsp_pkg::PH_ERROR;
        end
      endcase

      if (line_end) begin
        lcnt_d = '0;
      end else if (lcnt_q >= MaxLine) begin
        phase_d = mdsp_pkg::PH_ERROR;
      end else begin
        lcnt_d = lcnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (phase_d == mdsp_pkg::PH_DONE) begin
      st = mdsp_pkg::ST_DONE;
    end else if (phase_d >= mdsp_pkg::PH_ERROR) begin
      st = mdsp_pkg::ST_ERR;
    end else begin
      st = mdsp_pkg::ST_RUN;
    end
  end

  // Result entries; a byte with no output gives one status-only entry.
  always_comb begin
    ent0.data          = e0;
    ent0.has_byte      = (e_n != 2'd0);
    ent0.to_first_line = e0_first;
    ent0.last          = (e_n != 2'd2);
    ent0.status        = st;
    ent1.data          = e1;
    ent1.has_byte      = 1'b1;
    ent1.to_first_line = 1'b0;
    ent1.last          = 1'b1;
    ent1.status        = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unstuff_q <= 1'b1;
      phase_q   <= mdsp_pkg::PH_FIRST;
      cr_q      <= 1'b0;
      lcnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unstuff_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        phase_q <= phase_d;
        cr_q    <= cr_d;
        lcnt_q  <= lcnt_d;
      end
    end
  end

  // ------------------------------------------------------------------
  // Result queue: up to two entries in per transfer, one out
  // ------------------------------------------------------------------
  mdsp_pkg::res_t      q_mem [OUT_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     wr_n;

  assign wr_n = in_fire ? ((e_n == 2'd2) ? CntW'(2) : CntW'(1)) : '0;
  assign cnt_d = cnt_q + wr_n - CntW'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(wr_n);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      q_mem[wr_ptr_q] <= ent0;
      if (e_n == 2'd2) begin
        q_mem[wr_ptr_q + 1'b1] <= ent1;
      end
    end
  end

  assign in_stall_o          = (cnt_q > StallAt);
  assign out_valid_o         = (cnt_q != '0);
  assign out_byte_o          = q_mem[rd_ptr_q].data;
  assign out_has_byte_o      = q_mem[rd_ptr_q].has_byte;
  assign out_to_first_line_o = q_mem[rd_ptr_q].to_first_line;
  assign out_last_o          = q_mem[rd_ptr_q].last;
  assign out_status_o        = q_mem[rd_ptr_q].status;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(OUT_DEPTH))
    else $error("result queue overflow");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted byte left no result");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mdsp_pkg::PH_DONE |=> phase_q == mdsp_pkg::PH_DONE)
    else $error("left done phase");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mdsp_pkg::PH_ERROR |=> phase_q == mdsp_pkg::PH_ERROR)
    else $error("left error phase");

  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_has_byte_o |-> out_last_o && !out_to_first_line_o)
    else $error("status-only result not marked last");

endmodule : multiline_dot_stuffing_parser

`default_nettype wire
